// ===== rtl/rbsd_pkg.sv =====
// Shared types and constants of the repetition BPSK soft decoder.
package rbsd_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_CARRIERS = 128;
    localparam int DEF_MAX_BITS     = 14;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Fixed widths of the register file and of the result fields.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_W     = 128;
    localparam int CI_W       = 7;
    localparam int LEN_W      = 8;
    localparam int NB_W       = 4;
    localparam int REL_W      = 23;
    localparam int DBITS_W    = 14;

    // Register values after reset.
    localparam logic [LEN_W-1:0] RST_SYMBOL_LENGTH = 8'd128;
    localparam logic [NB_W-1:0]  RST_BITS_PER_WORD = 4'd8;
    localparam logic [REL_W-1:0] RST_WEAK_THRESH   = 23'd10240;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOL_LENGTH  = 3'd0,
        CFG_BITS_PER_WORD  = 3'd1,
        CFG_EXCLUDED_LOW   = 3'd2,
        CFG_EXCLUDED_HIGH  = 3'd3,
        CFG_WHITENER_LOW   = 3'd4,
        CFG_WHITENER_HIGH  = 3'd5,
        CFG_WEAK_THRESHOLD = 3'd6
    } t_cfg_idx;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]  symbol_length;
        logic [NB_W-1:0]   bits_per_word;
        logic [MASK_W-1:0] excluded;
        logic [MASK_W-1:0] whitener;
        logic [REL_W-1:0]  weak_threshold;
    } t_cfg;

endpackage

// ===== rtl/rbsd_cfg_regs.sv =====
// Configuration register file of the repetition BPSK soft decoder.
module rbsd_cfg_regs
    import rbsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.symbol_length  <= RST_SYMBOL_LENGTH;
            r_cfg.bits_per_word  <= RST_BITS_PER_WORD;
            r_cfg.excluded       <= '0;
            r_cfg.whitener       <= '0;
            r_cfg.weak_threshold <= RST_WEAK_THRESH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SYMBOL_LENGTH:  r_cfg.symbol_length <= i_cfg_data[LEN_W-1:0];
                CFG_BITS_PER_WORD:  r_cfg.bits_per_word <= i_cfg_data[NB_W-1:0];
                CFG_EXCLUDED_LOW:   r_cfg.excluded[CFG_DATA_W-1:0] <= i_cfg_data;
                CFG_EXCLUDED_HIGH:  r_cfg.excluded[MASK_W-1:CFG_DATA_W] <= i_cfg_data;
                CFG_WHITENER_LOW:   r_cfg.whitener[CFG_DATA_W-1:0] <= i_cfg_data;
                CFG_WHITENER_HIGH:  r_cfg.whitener[MASK_W-1:CFG_DATA_W] <= i_cfg_data;
                CFG_WEAK_THRESHOLD: r_cfg.weak_threshold <= i_cfg_data[REL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/rbsd_acc_mem.sv =====
// Soft accumulator memory with registered read and per-entry valid bits.
module rbsd_acc_mem #(
    parameter int DEPTH  = 14,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_valid;

    // Storage array; a read at the written address returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/rbsd_decide.sv =====
// Hard decision and minimum magnitude search over the accumulators of a symbol.
module rbsd_decide
    import rbsd_pkg::*;
#(
    parameter int MAX_BITS = DEF_MAX_BITS,
    parameter int ACC_W    = 24,
    parameter int SLOT_W   = 4
) (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_fold,
    input  logic [SLOT_W-1:0]  i_idx,
    input  logic [ACC_W-1:0]   i_acc,
    input  logic [NB_W-1:0]    i_nb,
    output logic [DBITS_W-1:0] o_word,
    output logic [ACC_W-1:0]   o_min
);

    logic [MAX_BITS-1:0] r_word;
    logic [ACC_W-1:0]    r_min;
    logic [MAX_BITS-1:0] n_word;
    logic [ACC_W-1:0]    n_min;
    logic                w_take;
    logic [ACC_W-1:0]    w_mag;

    // Fold the current accumulator into the running word and minimum.
    always_comb begin
        w_take = i_fold && (NB_W'(i_idx) < i_nb);
        w_mag  = i_acc[ACC_W-1] ? (ACC_W'(0) - i_acc) : i_acc;
        n_word = r_word;
        n_min  = r_min;
        if (w_take) begin
            if (i_acc[ACC_W-1]) begin
                n_word[i_idx] = 1'b1;
            end
            if (w_mag < r_min) begin
                n_min = w_mag;
            end
        end
    end

    // Running registers, restarted at the start of each sweep.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_word <= '0;
            r_min  <= '1;
        end else if (i_fold) begin
            r_word <= n_word;
            r_min  <= n_min;
        end
    end

    assign o_word = DBITS_W'(n_word);
    assign o_min  = n_min;

endmodule

// ===== rtl/repetition_bpsk_soft_decoder_unit.sv =====
// Top level of the repetition BPSK soft decoder.
// Each input transaction carries the real part of one subcarrier in carrier order.
// Every carrier is accepted in S_IDLE, which reads the accumulator of its slot
// from the accumulator memory, and then passes through S_ACCUM, which writes
// the updated sum back; an excluded carrier writes nothing. The last carrier
// of a symbol adds a sweep over all MAX_BITS memory entries, which reads each
// accumulator, folds it into the decision and writes it back as zero; S_FINISH
// then waits for the output register to be free before the result transaction
// is offered. The result sits in the output register,
// and the next symbol's carriers are taken while it waits; only a second
// finished symbol waits for the first result to be taken. Configuration
// writes are taken in every cycle and must be issued only while no carrier
// transaction is in progress, that is while the input channel is ready.
module repetition_bpsk_soft_decoder_unit
    import rbsd_pkg::*;
#(
    parameter int MAX_CARRIERS = DEF_MAX_CARRIERS,
    parameter int MAX_BITS     = DEF_MAX_BITS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_real,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [DBITS_W-1:0]      o_data_bits,
    output logic [REL_W-1:0]        o_reliability,
    output logic                    o_weak_res,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ACC_W  = SAMPLE_WIDTH + $clog2(MAX_CARRIERS) + 1;
    localparam int SLOT_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int CMP_W  = (ACC_W > REL_W) ? ACC_W : REL_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ACCUM  = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_cfg               w_cfg;
    t_state             r_state;
    logic [CI_W-1:0]    r_carrier;
    logic [CI_W-1:0]    r_used;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_slot_use;
    logic [ACC_W-1:0]   r_x;
    logic               r_use;
    logic               r_last;
    logic [SLOT_W-1:0]  r_sweep;
    logic               r_chk_valid;
    logic [SLOT_W-1:0]  r_chk_idx;
    logic               r_out_valid;
    logic [DBITS_W-1:0] r_data_bits;
    logic [REL_W-1:0]   r_reliability;
    logic               r_weak;

    logic [LEN_W-1:0]   w_len;
    logic [NB_W-1:0]    w_nb;
    logic               w_accept;
    logic               w_excl;
    logic               w_white;
    logic [SLOT_W-1:0]  w_slot_use;
    logic [SLOT_W-1:0]  w_slot_next;
    logic [ACC_W-1:0]   w_x_ext;
    logic               w_last;
    logic               w_out_free;
    logic               w_fold;
    logic               w_rd_en;
    logic [SLOT_W-1:0]  w_rd_addr;
    logic [ACC_W-1:0]   w_rd_data;
    logic               w_wr_en;
    logic [SLOT_W-1:0]  w_wr_addr;
    logic [ACC_W-1:0]   w_wr_data;
    logic [DBITS_W-1:0] w_word;
    logic [ACC_W-1:0]   w_min;

    rbsd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Clamp symbol length and period to their legal ranges.
    always_comb begin
        w_len = w_cfg.symbol_length;
        if (w_len == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len > LEN_W'(MAX_CARRIERS)) begin
            w_len = LEN_W'(MAX_CARRIERS);
        end
        w_nb = w_cfg.bits_per_word;
        if (w_nb == '0) begin
            w_nb = NB_W'(1);
        end else if (w_nb > NB_W'(MAX_BITS)) begin
            w_nb = NB_W'(MAX_BITS);
        end
    end

    // Per-carrier decode of exclusion, whitening, slot and symbol end.
    always_comb begin
        w_accept    = i_valid && (r_state == S_IDLE);
        w_excl      = w_cfg.excluded[r_carrier];
        w_white     = w_cfg.whitener[r_used];
        w_slot_use  = (NB_W'(r_slot) >= w_nb) ? '0 : r_slot;
        w_slot_next = ((NB_W'(w_slot_use) + NB_W'(1)) >= w_nb) ? '0
                                                              : w_slot_use + SLOT_W'(1);
        w_x_ext     = {{(ACC_W-SAMPLE_WIDTH){i_sample_real[SAMPLE_WIDTH-1]}}, i_sample_real};
        w_last      = (LEN_W'(r_carrier) + LEN_W'(1)) >= w_len;
        w_out_free  = !r_out_valid || i_ready;
    end

    // Memory port selection: read-modify-write per carrier, sweep at symbol end.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_slot_use;
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot_use;
        w_wr_data = w_rd_data + r_x;
        unique case (r_state)
            S_IDLE: begin
                w_rd_en = w_accept;
            end
            S_ACCUM: begin
                w_wr_en = r_use;
            end
            S_SWEEP: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_sweep;
                w_wr_en   = 1'b1;
                w_wr_addr = r_sweep;
                w_wr_data = '0;
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    rbsd_acc_mem #(
        .DEPTH  (MAX_BITS),
        .WIDTH  (ACC_W),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    assign w_fold = r_chk_valid && ((r_state == S_SWEEP) || (r_state == S_FINISH));

    rbsd_decide #(
        .MAX_BITS (MAX_BITS),
        .ACC_W    (ACC_W),
        .SLOT_W   (SLOT_W)
    ) u_decide (
        .i_clk   (i_clk),
        .i_clear ((r_state == S_ACCUM) && r_last),
        .i_fold  (w_fold),
        .i_idx   (r_chk_idx),
        .i_acc   (w_rd_data),
        .i_nb    (w_nb),
        .o_word  (w_word),
        .o_min   (w_min)
    );

    // Sequencer and symbol counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_carrier   <= '0;
            r_used      <= '0;
            r_slot      <= '0;
            r_use       <= 1'b0;
            r_last      <= 1'b0;
            r_sweep     <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_use   <= !w_excl;
                        r_last  <= w_last;
                        r_state <= S_ACCUM;
                        if (w_last) begin
                            r_carrier <= '0;
                            r_used    <= '0;
                            r_slot    <= '0;
                        end else begin
                            r_carrier <= r_carrier + CI_W'(1);
                            if (!w_excl) begin
                                r_used <= r_used + CI_W'(1);
                                r_slot <= w_slot_next;
                            end
                        end
                    end
                end
                S_ACCUM: begin
                    r_sweep     <= '0;
                    r_chk_valid <= 1'b0;
                    r_state     <= r_last ? S_SWEEP : S_IDLE;
                end
                S_SWEEP: begin
                    r_chk_valid <= 1'b1;
                    r_sweep     <= r_sweep + SLOT_W'(1);
                    if (r_sweep == SLOT_W'(MAX_BITS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Carrier payload held from acceptance to write-back, and sweep pipeline index.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot_use <= w_slot_use;
            r_x        <= w_white ? (ACC_W'(0) - w_x_ext) : w_x_ext;
        end
        if (r_state == S_SWEEP) begin
            r_chk_idx <= r_sweep;
        end
    end

    // Output register of the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && w_out_free) begin
            r_data_bits   <= w_word;
            r_reliability <= REL_W'(w_min);
            r_weak        <= CMP_W'(w_min) <= CMP_W'(w_cfg.weak_threshold);
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_data_bits   = r_data_bits;
    assign o_reliability = r_reliability;
    assign o_weak_res    = r_weak;

endmodule

// ===== rtl/rbsd_checker.sv =====
// Port-level checks of the repetition BPSK soft decoder, bound to its top level.
module rbsd_checker
    import rbsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic [SAMPLE_WIDTH-1:0] i_sample_real,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [DBITS_W-1:0]      o_data_bits,
    input logic [REL_W-1:0]        o_reliability,
    input logic                    o_weak_res
);

    // A pending result stays offered with its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_bits) && $stable(o_reliability))
        else $error("result transaction dropped or changed while stalled");

    // A waiting input transaction keeps its sample until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_sample_real))
        else $error("input transaction dropped or changed while waiting");

    // Every input transaction is followed by the accumulator write-back state, in which no input is taken.
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted during an accumulator write-back");

    // A zero reliability always counts as weak.
    a_zero_weak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_reliability == '0) |-> o_weak_res)
        else $error("zero reliability not flagged weak");

    // A new result only appears as a finished symbol leaves its finish state, in which the input channel is not ready.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without a finished symbol");

endmodule

bind repetition_bpsk_soft_decoder_unit rbsd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rbsd_checker (.*);
